### hw/rtl/lpr_pkg.sv
package lpr_pkg;

  // Sequencer states of the frame table
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } lpr_state_t;

  // Running totals
  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

### hw/rtl/lpr_ram.sv
module lpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/lru_page_replacement.sv
// Each accepted page word is scanned across all frames, then its result word is registered on out_valid.
// A new page reference is taken only after the previous one commits; the scan uses the single page
//   comparator, which reads the frame page RAM one frame per cycle.
// A finished result may wait in the output register while the next page is accepted.
// Reset (rst_n low, synchronous): all frames empty, ranks and totals zero;
//   the frame page RAM is not cleared, empty frames are never matched.
module lru_page_replacement import lpr_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PAGE_BITS-1:0]      in_page_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [$clog2(FRAMES)-1:0] out_frame_index,
  output logic                      out_evicted_valid,
  output logic [PAGE_BITS-1:0]      out_evicted_page,
  output logic [CNT_W-1:0]          out_fault_total,
  output logic [CNT_W-1:0]          out_hit_total
);

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);

  lpr_state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 eval_vld_r, eval_vld_nxt;
  logic [IW-1:0]        eval_idx_r, eval_idx_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;

  logic                 hit_found_r, hit_found_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]        hit_rank_r, hit_rank_nxt;
  logic                 empty_found_r, empty_found_nxt;
  logic [IW-1:0]        empty_idx_r, empty_idx_nxt;
  logic [IW-1:0]        vic_idx_r, vic_idx_nxt;
  logic [IW-1:0]        vic_rank_r, vic_rank_nxt;
  logic [PAGE_BITS-1:0] vic_page_r, vic_page_nxt;

  logic [FRAMES-1:0]    valid_r, valid_nxt;
  logic [IW-1:0]        rank_r [FRAMES];
  logic [IW-1:0]        rank_nxt [FRAMES];
  logic [CNT_W-1:0]     fault_cnt_r, fault_cnt_nxt;
  logic [CNT_W-1:0]     hit_cnt_r, hit_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [IW-1:0]        out_idx_r, out_idx_nxt;
  logic                 out_ev_vld_r, out_ev_vld_nxt;
  logic [PAGE_BITS-1:0] out_ev_page_r, out_ev_page_nxt;

  // Sequencer controls
  logic                 accept;
  logic                 scan_issue;
  logic                 commit;
  logic [IW-1:0]        rd_addr;
  logic [PAGE_BITS-1:0] rd_page;

  // Decision for the current reference
  logic                 dec_hit;
  logic                 dec_age_all;
  logic [IW-1:0]        dec_frame;
  logic [IW-1:0]        dec_limit;

  // Frame page store, read one frame per cycle during the scan
  lpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (commit && !dec_hit),
    .wr_addr (dec_frame),
    .wr_data (page_r),
    .rd_addr (rd_addr),
    .rd_data (rd_page)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(FRAMES)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept     = 1'b0;
    scan_issue = 1'b0;
    commit     = 1'b0;
    case (state_r)
      ST_IDLE:   accept     = in_valid;
      ST_SCAN:   scan_issue = (cnt_r < CW'(FRAMES));
      ST_DECIDE: commit     = !(out_valid_r && out_stall);
      default: begin
        accept = 1'b0;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign rd_addr  = scan_issue ? cnt_r[IW-1:0] : '0;

  // Pick the frame: hit frame, else first empty frame, else oldest frame
  always_comb begin
    dec_hit     = hit_found_r;
    dec_age_all = !hit_found_r && empty_found_r;
    if (hit_found_r) begin
      dec_frame = hit_idx_r;
      dec_limit = hit_rank_r;
    end else if (empty_found_r) begin
      dec_frame = empty_idx_r;
      dec_limit = '0;
    end else begin
      dec_frame = vic_idx_r;
      dec_limit = vic_rank_r;
    end
  end

  // Datapath: scan accumulation, recency update, totals, output register
  always_comb begin
    cnt_nxt         = cnt_r;
    eval_vld_nxt    = 1'b0;
    eval_idx_nxt    = eval_idx_r;
    page_nxt        = page_r;
    hit_found_nxt   = hit_found_r;
    hit_idx_nxt     = hit_idx_r;
    hit_rank_nxt    = hit_rank_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    vic_idx_nxt     = vic_idx_r;
    vic_rank_nxt    = vic_rank_r;
    vic_page_nxt    = vic_page_r;
    valid_nxt       = valid_r;
    rank_nxt        = rank_r;
    fault_cnt_nxt   = fault_cnt_r;
    hit_cnt_nxt     = hit_cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_hit_nxt     = out_hit_r;
    out_idx_nxt     = out_idx_r;
    out_ev_vld_nxt  = out_ev_vld_r;
    out_ev_page_nxt = out_ev_page_r;

    // Latch the page word and clear the scan flags
    if (accept) begin
      page_nxt        = in_page_number;
      cnt_nxt         = '0;
      hit_found_nxt   = 1'b0;
      empty_found_nxt = 1'b0;
    end

    // Issue one frame read per cycle
    if (scan_issue) begin
      cnt_nxt      = cnt_r + 1'b1;
      eval_vld_nxt = 1'b1;
      eval_idx_nxt = cnt_r[IW-1:0];
    end

    // Compare the frame read last cycle
    if (eval_vld_r) begin
      if (valid_r[eval_idx_r] && (rd_page == page_r) && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = eval_idx_r;
        hit_rank_nxt  = rank_r[eval_idx_r];
      end
      if (!valid_r[eval_idx_r] && !empty_found_r) begin
        empty_found_nxt = 1'b1;
        empty_idx_nxt   = eval_idx_r;
      end
      if ((eval_idx_r == '0) || (rank_r[eval_idx_r] > vic_rank_r)) begin
        vic_idx_nxt  = eval_idx_r;
        vic_rank_nxt = rank_r[eval_idx_r];
        vic_page_nxt = rd_page;
      end
    end

    // Commit: age younger frames, make the chosen frame most recent, count the result, load the output register
    if (commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IW'(i) == dec_frame) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i] && (dec_age_all || (rank_r[i] < dec_limit))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      if (dec_hit) begin
        if (hit_cnt_r != CNT_MAX) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
      end else if (fault_cnt_r != CNT_MAX) begin
        fault_cnt_nxt = fault_cnt_r + 1'b1;
      end
      out_valid_nxt   = 1'b1;
      out_hit_nxt     = dec_hit;
      out_idx_nxt     = dec_frame;
      out_ev_vld_nxt  = !dec_hit && !empty_found_r;
      out_ev_page_nxt = (!dec_hit && !empty_found_r) ? vic_page_r : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      eval_vld_r    <= 1'b0;
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      valid_r       <= '0;
      rank_r        <= '{default: '0};
      fault_cnt_r   <= '0;
      hit_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      eval_vld_r    <= eval_vld_nxt;
      hit_found_r   <= hit_found_nxt;
      empty_found_r <= empty_found_nxt;
      valid_r       <= valid_nxt;
      rank_r        <= rank_nxt;
      fault_cnt_r   <= fault_cnt_nxt;
      hit_cnt_r     <= hit_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eval_idx_r    <= eval_idx_nxt;
    page_r        <= page_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_rank_r    <= hit_rank_nxt;
    empty_idx_r   <= empty_idx_nxt;
    vic_idx_r     <= vic_idx_nxt;
    vic_rank_r    <= vic_rank_nxt;
    vic_page_r    <= vic_page_nxt;
    out_hit_r     <= out_hit_nxt;
    out_idx_r     <= out_idx_nxt;
    out_ev_vld_r  <= out_ev_vld_nxt;
    out_ev_page_r <= out_ev_page_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_idx_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = fault_cnt_r;
  assign out_hit_total     = hit_cnt_r;

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_vld_r))
    else $error("hit word reports an eviction");

  // An accepted word always starts a scan from frame zero
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted word did not start a scan");

  // Resident frames are never dropped
  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) >= $countones($past(valid_r))))
    else $error("resident frame count fell");

  // Totals move only on commit
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(fault_cnt_r) && $stable(hit_cnt_r))
    else $error("totals changed outside commit");

endmodule

### dv/tb_top.sv
module tb_top;
  import lpr_pkg::*;

  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned IDX_W     = $clog2(FRAMES);
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PHASE_WORDS = 360;

  // One result word as the block reports it
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     fault_total;
    logic [CNT_W-1:0]     hit_total;
  } frame_result_t;

  // Shadow frame table plus the queue of results still owed by the block
  class frame_table_checker;
    logic [PAGE_BITS-1:0] page_of[FRAMES];
    bit                   held[FRAMES];
    int unsigned          age[FRAMES];
    logic [CNT_W-1:0]     faults;
    logic [CNT_W-1:0]     hits;
    frame_result_t        owed[$];
    int unsigned          errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        page_of[i] = '0;
        held[i]    = 1'b0;
        age[i]     = 0;
      end
      faults = '0;
      hits   = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Work out the result of one accepted page reference and queue it
    function void note_reference(logic [PAGE_BITS-1:0] page);
      frame_result_t r;
      int            slot;
      int            victim;
      int unsigned   limit;
      r      = '0;
      slot   = -1;
      victim = 0;
      limit  = 0;
      for (int i = 0; i < FRAMES; i++)
        if (slot < 0 && held[i] && page_of[i] == page) slot = i;
      if (slot >= 0) begin
        r.hit = 1'b1;
        limit = age[slot];
        if (hits != CNT_MAX) hits++;
      end else begin
        if (faults != CNT_MAX) faults++;
        // take the lowest empty frame, else the oldest one
        for (int i = 0; i < FRAMES; i++)
          if (slot < 0 && !held[i]) slot = i;
        if (slot >= 0) begin
          limit = FRAMES + 1;
        end else begin
          for (int i = 1; i < FRAMES; i++)
            if (age[i] > age[victim]) victim = i;
          slot            = victim;
          r.evicted_valid = 1'b1;
          r.evicted_page  = page_of[slot];
          limit           = age[slot];
        end
        page_of[slot] = page;
      end
      // age the frames younger than the touched one
      for (int i = 0; i < FRAMES; i++)
        if (i != slot && held[i] && age[i] < limit) age[i]++;
      age[slot]     = 0;
      held[slot]    = 1'b1;
      r.frame_index = slot[IDX_W-1:0];
      r.fault_total = faults;
      r.hit_total   = hits;
      owed.push_back(r);
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest one owed
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed.size() == 0) begin
        $display("%0t unexpected result word: expected none, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      check_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
      check_field("frame_index", CNT_W'(want.frame_index), CNT_W'(got.frame_index));
      check_field("evicted_valid", CNT_W'(want.evicted_valid), CNT_W'(got.evicted_valid));
      check_field("evicted_page", CNT_W'(want.evicted_page), CNT_W'(got.evicted_page));
      check_field("fault_total", want.fault_total, got.fault_total);
      check_field("hit_total", want.hit_total, got.hit_total);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] in_page_number = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic [IDX_W-1:0]     out_frame_index;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [CNT_W-1:0]     out_fault_total;
  logic [CNT_W-1:0]     out_hit_total;

  frame_table_checker sb = new();

  int unsigned          in_idle_pct = 0;
  int unsigned          out_stall_pct = 0;
  int unsigned          hold_len = 0;
  logic [PAGE_BITS-1:0] working_set[16];
  int unsigned          set_size = 8;
  frame_result_t        seen;

  lru_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_hit_total     (out_hit_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check result words first, then note page words accepted on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.hit           = out_hit;
        seen.frame_index   = out_frame_index;
        seen.evicted_valid = out_evicted_valid;
        seen.evicted_page  = out_evicted_page;
        seen.fault_total   = out_fault_total;
        seen.hit_total     = out_hit_total;
        sb.check_result(seen);
      end
      if (in_valid && !in_stall) sb.note_reference(in_page_number);
    end
  end

  // Receiver: random stalls, or one long hold when asked
  initial begin
    wait (rst_n);
    forever begin
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Watchdog: give up after too many cycles with no word moving
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("status: fail");
    $finish;
  end

  // Offer one page word, with random idle cycles ahead of it, and hold until taken
  task automatic send_page(input logic [PAGE_BITS-1:0] page);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering until every owed result word has come back; step one edge first
  // so the word accepted on the last edge is already counted as owed
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Pick a fresh working set; sizes around FRAMES mix hits with evictions
  task automatic refresh_working_set();
    set_size = $urandom_range(16, 3);
    for (int i = 0; i < 16; i++) working_set[i] = PAGE_BITS'($urandom);
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_page();
    if ($urandom_range(99) < 82) return working_set[$urandom_range(set_size - 1)];
    return PAGE_BITS'($urandom);
  endfunction

  task automatic run_references(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) refresh_working_set();
      send_page(pick_page());
    end
  endtask

  initial begin
    logic [PAGE_BITS-1:0] directed_pages[] = '{
      // fill every frame, extremes first
      16'h0000, 16'hFFFF, 16'h1234, 16'hABCD, 16'h8000, 16'h0001, 16'h7FFF, 16'h5555,
      // hit on the oldest, the youngest and a middle frame
      16'h0000, 16'h0000, 16'h5555, 16'hABCD,
      // misses on a full table replace the oldest frame
      16'hAAAA, 16'h0F0F, 16'hFFFF, 16'h1234,
      // hit two recent arrivals, bring back an evicted page, then miss on a new page
      16'hAAAA, 16'h0F0F, 16'h8000, 16'hF0F0
    };
    int unsigned idle_tab[5]  = '{0, 72, 0, 34, 0};
    int unsigned stall_tab[5] = '{0, 0, 72, 34, 0};

    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed references at full rate
    foreach (directed_pages[i]) send_page(directed_pages[i]);
    wait_drained();

    // hold the receiver off while pages keep coming, so the input backs up
    refresh_working_set();
    hold_len = HOLD_CYCLES;
    repeat (40) send_page(pick_page());
    wait_drained();

    // random references under each idling mix
    for (int ph = 0; ph < 5; ph++) begin
      in_idle_pct   = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      run_references(PHASE_WORDS);
      wait_drained();
    end

    // let any stray result word show up before the verdict
    out_stall_pct = 0;
    repeat (FRAMES + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
